[rtl/pida_pkg.sv]
`default_nettype none

package pida_pkg;

   // fixed field widths of the channels
   localparam int KIND_W   = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam kind_type KIND_CLEAR  = 3'd0;
   localparam kind_type KIND_APPEND = 3'd1;
   localparam kind_type KIND_INSERT = 3'd2;
   localparam kind_type KIND_DELETE = 3'd3;
   localparam kind_type KIND_DUMP   = 3'd4;

   // result status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;
   localparam status_type ST_BADPOS = 2'd3;

   // pointer update
   typedef logic [2:0] ptr_op_type;
   localparam ptr_op_type PTR_HOLD = 3'd0;
   localparam ptr_op_type PTR_FILL = 3'd1;
   localparam ptr_op_type PTR_POS  = 3'd2;
   localparam ptr_op_type PTR_ZERO = 3'd3;
   localparam ptr_op_type PTR_INC  = 3'd4;
   localparam ptr_op_type PTR_DEC  = 3'd5;

   // fill count update
   typedef logic [1:0] fill_op_type;
   localparam fill_op_type FILL_HOLD  = 2'd0;
   localparam fill_op_type FILL_CLEAR = 2'd1;
   localparam fill_op_type FILL_INC   = 2'd2;
   localparam fill_op_type FILL_DEC   = 2'd3;

   // memory read address relative to the pointer
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_PTR  = 2'd0;
   localparam rd_sel_type RD_DOWN = 2'd1;
   localparam rd_sel_type RD_UP   = 2'd2;

   // source of the result data field
   typedef logic [1:0] dsel_type;
   localparam dsel_type DSEL_ZERO  = 2'd0;
   localparam dsel_type DSEL_VAL   = 2'd1;
   localparam dsel_type DSEL_RDATA = 2'd2;

   // controller to datapath
   typedef struct packed {
      ptr_op_type  ptr_op;
      logic        pos_load;
      logic        pos_from_fill;
      logic        val_load;
      logic        val_from_rdata;
      rd_sel_type  rd_sel;
      logic        mem_wr;
      logic        wr_from_rdata;
      fill_op_type fill_op;
      logic        rsp_load;
      status_type  rsp_status;
      dsel_type    rsp_data_sel;
      logic        rsp_index_ptr;
      logic        rsp_last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic ins_badpos;
      logic del_badpos;
      logic ptr_above_pos;
      logic ptr_next_in;
      logic rsp_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/pida_datapath.sv]
`default_nettype none

module pida_datapath
   import pida_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [VALUE_W-1:0] req_value,
   input  wire dp_cmd_type                cmd,
   output dp_stat_type                    stat,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic signed [DATA_W-1:0]       rsp_data,
   output logic [INDEX_W-1:0]             rsp_index,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > POS_W) ? FW : POS_W;

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [CW-1:0]         pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] wdata;
   logic [DATA_WIDTH-1:0] sel_data;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_last_ff;

   // pointer next value
   always_comb begin
      ptr_in = ptr_ff;
      case (cmd.ptr_op)
         PTR_FILL: ptr_in = AW'(fill_ff);
         PTR_POS:  ptr_in = AW'(req_position);
         PTR_ZERO: ptr_in = '0;
         PTR_INC:  ptr_in = ptr_ff + AW'(1);
         PTR_DEC:  ptr_in = ptr_ff - AW'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   // fill count next value
   always_comb begin
      fill_in = fill_ff;
      case (cmd.fill_op)
         FILL_CLEAR: fill_in = '0;
         FILL_INC:   fill_in = fill_ff + FW'(1);
         FILL_DEC:   fill_in = fill_ff - FW'(1);
         default:    fill_in = fill_ff;
      endcase
   end

   // read address around the pointer
   always_comb begin
      case (cmd.rd_sel)
         RD_DOWN: rd_addr = ptr_ff - AW'(1);
         RD_UP:   rd_addr = ptr_ff + AW'(1);
         default: rd_addr = ptr_ff;
      endcase
   end

   assign wdata = cmd.wr_from_rdata ? rdata_ff : val_ff;

   // result data source
   always_comb begin
      case (cmd.rsp_data_sel)
         DSEL_VAL:   sel_data = val_ff;
         DSEL_RDATA: sel_data = rdata_ff;
         default:    sel_data = '0;
      endcase
   end

   // entry store, written at the pointer, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem_ff[ptr_ff] <= wdata;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.pos_load) begin
         pos_ff <= cmd.pos_from_fill ? CW'(fill_ff) : CW'(req_position);
      end
      if (cmd.val_load) begin
         val_ff <= cmd.val_from_rdata ? rdata_ff : DATA_WIDTH'(req_value);
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_data_ff   <= DATA_W'(sel_data);
         rsp_index_ff  <= cmd.rsp_index_ptr ? INDEX_W'(ptr_ff) : '0;
         rsp_count_ff  <= COUNT_W'(fill_in);
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   // status towards the controller
   always_comb begin
      stat.full          = (fill_ff == FW'(DEPTH));
      stat.empty         = (fill_ff == '0);
      stat.ins_badpos    = (CW'(req_position) > CW'(fill_ff));
      stat.del_badpos    = (CW'(req_position) >= CW'(fill_ff));
      stat.ptr_above_pos = (CW'(ptr_ff) > pos_ff);
      stat.ptr_next_in   = ((CW'(ptr_ff) + CW'(1)) < CW'(fill_ff));
      stat.rsp_busy      = rsp_valid_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/pida_ctrl.sv]
`default_nettype none

module pida_ctrl
   import pida_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire dp_stat_type       stat,
   output dp_cmd_type             cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INS_CHECK = 4'd1;
   localparam logic [3:0] S_INS_MOVE  = 4'd2;
   localparam logic [3:0] S_DEL_READ  = 4'd3;
   localparam logic [3:0] S_DEL_GRAB  = 4'd4;
   localparam logic [3:0] S_DEL_CHECK = 4'd5;
   localparam logic [3:0] S_DEL_MOVE  = 4'd6;
   localparam logic [3:0] S_DUMP_READ = 4'd7;
   localparam logic [3:0] S_DUMP_SEND = 4'd8;

   logic [3:0] state_ff, state_in;

   // new beats only when idle and the result register is free
   assign req_stall = (state_ff != S_IDLE) || stat.rsp_busy;

   // sequencing of the operations
   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.ptr_op       = PTR_HOLD;
      cmd.rd_sel       = RD_PTR;
      cmd.fill_op      = FILL_HOLD;
      cmd.rsp_status   = ST_OK;
      cmd.rsp_data_sel = DSEL_ZERO;
      cmd.rsp_last     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               unique case (req_kind)
                  KIND_CLEAR: begin
                     cmd.fill_op  = FILL_CLEAR;
                     cmd.rsp_load = 1'b1;
                  end
                  KIND_APPEND: begin
                     if (stat.full) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        // an append is an insert at the fill position
                        cmd.ptr_op        = PTR_FILL;
                        cmd.pos_load      = 1'b1;
                        cmd.pos_from_fill = 1'b1;
                        cmd.val_load      = 1'b1;
                        state_in          = S_INS_CHECK;
                     end
                  end
                  KIND_INSERT: begin
                     if (stat.full) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_FULL;
                     end else if (stat.ins_badpos) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_BADPOS;
                     end else begin
                        cmd.ptr_op   = PTR_FILL;
                        cmd.pos_load = 1'b1;
                        cmd.val_load = 1'b1;
                        state_in     = S_INS_CHECK;
                     end
                  end
                  KIND_DELETE: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else if (stat.del_badpos) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_BADPOS;
                     end else begin
                        cmd.ptr_op = PTR_POS;
                        state_in   = S_DEL_READ;
                     end
                  end
                  KIND_DUMP: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.ptr_op = PTR_ZERO;
                        state_in   = S_DUMP_READ;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         // walk down from the fill position, opening a gap
         S_INS_CHECK: begin
            if (stat.ptr_above_pos) begin
               cmd.rd_sel = RD_DOWN;
               state_in   = S_INS_MOVE;
            end else begin
               cmd.mem_wr   = 1'b1;
               cmd.fill_op  = FILL_INC;
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_INS_MOVE: begin
            cmd.mem_wr        = 1'b1;
            cmd.wr_from_rdata = 1'b1;
            cmd.ptr_op        = PTR_DEC;
            state_in          = S_INS_CHECK;
         end
         // fetch the entry being removed
         S_DEL_READ: begin
            cmd.rd_sel = RD_PTR;
            state_in   = S_DEL_GRAB;
         end
         S_DEL_GRAB: begin
            cmd.val_load       = 1'b1;
            cmd.val_from_rdata = 1'b1;
            state_in           = S_DEL_CHECK;
         end
         // walk up to the top, closing the gap
         S_DEL_CHECK: begin
            if (stat.ptr_next_in) begin
               cmd.rd_sel = RD_UP;
               state_in   = S_DEL_MOVE;
            end else begin
               cmd.fill_op      = FILL_DEC;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_data_sel = DSEL_VAL;
               state_in         = S_IDLE;
            end
         end
         S_DEL_MOVE: begin
            cmd.mem_wr        = 1'b1;
            cmd.wr_from_rdata = 1'b1;
            cmd.ptr_op        = PTR_INC;
            state_in          = S_DEL_CHECK;
         end
         // one result beat per stored entry
         S_DUMP_READ: begin
            cmd.rd_sel = RD_PTR;
            if (!stat.rsp_busy) begin
               state_in = S_DUMP_SEND;
            end
         end
         S_DUMP_SEND: begin
            cmd.rsp_load      = 1'b1;
            cmd.rsp_data_sel  = DSEL_RDATA;
            cmd.rsp_index_ptr = 1'b1;
            cmd.rsp_last      = !stat.ptr_next_in;
            if (stat.ptr_next_in) begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_DUMP_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/positional_insert_delete_array.sv]
`default_nettype none

// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_kind, req_position, req_value
// rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_data, rsp_index, rsp_count, rsp_last
//
// clear, unused kinds and every error case: result in the cycle after the beat; append: via
// S_INS_CHECK. insert: S_INS_CHECK/S_INS_MOVE per entry moved; delete: S_DEL_READ, S_DEL_GRAB,
// then S_DEL_CHECK/S_DEL_MOVE per entry moved; both set by the single read and single
// write port of the entry store. dump: S_DUMP_READ/S_DUMP_SEND per entry, waits out rsp_stall.
// reset (synchronous) empties the array at once; entries above the count are never read.
// req_stall is high while an operation runs or a result beat waits.

module positional_insert_delete_array
   import pida_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic signed [DATA_W-1:0]       rsp_data,
   output logic [INDEX_W-1:0]             rsp_index,
   output logic [COUNT_W-1:0]             rsp_count,
   output logic                           rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // operation sequencer
   pida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry store, count and result register
   pida_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_position (req_position),
      .req_value    (req_value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_index    (rsp_index),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top
   import pida_pkg::*;
();

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 200;
   localparam int CALM_TAIL    = 30;
   localparam int HOLD_AT      = 45;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_AT     = 100;
   localparam int SETTLE       = 40;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int REPORT_CAP   = 200;

   // one request beat waiting to be driven
   typedef struct {
      kind_type                    kind;
      logic [POS_W-1:0]            position;
      logic signed [VALUE_W-1:0]   value;
      bit                          drain_first;
   } array_op_type;

   // one result beat as the array should produce it
   typedef struct {
      status_type                  status;
      logic signed [DATA_W-1:0]    data;
      logic [INDEX_W-1:0]          index;
      logic [COUNT_W-1:0]          count;
      logic                        last;
   } rsp_beat_type;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [KIND_W-1:0]             req_kind     = '0;
   logic [POS_W-1:0]              req_position = '0;
   logic signed [VALUE_W-1:0]     req_value    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [STATUS_W-1:0]           rsp_status;
   logic signed [DATA_W-1:0]      rsp_data;
   logic [INDEX_W-1:0]            rsp_index;
   logic [COUNT_W-1:0]            rsp_count;
   logic                          rsp_last;

   array_op_type                  op_backlog[$];
   rsp_beat_type                  owed_rsp[$];

   // shadow copy of the array contents
   logic signed [DATA_W-1:0]      shadow_words [0:DEPTH-1];
   int                            shadow_fill = 0;

   // fill level as the stimulus generator expects it
   int                            plan_fill = 0;

   int                            total_items = 0;
   int                            req_beats   = 0;
   int                            rsp_beats   = 0;
   int                            errors      = 0;
   int                            cycle_count = 0;
   int                            op_seen [0:7];
   logic                          req_taken   = 1'b0;
   int                            req_gap     = 0;
   int                            rsp_gap     = 0;
   int                            hold_left   = 0;
   bit                            hold_done   = 1'b0;

   positional_insert_delete_array dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_index    (rsp_index),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   // queue one operation and track the fill level it should leave behind
   task automatic queue_op(input kind_type k, input logic [POS_W-1:0] p,
                           input logic signed [VALUE_W-1:0] v, input bit drain);
      array_op_type op;
      op.kind        = k;
      op.position    = p;
      op.value       = v;
      op.drain_first = drain;
      op_backlog.push_back(op);
      case (k)
         KIND_CLEAR:  plan_fill = 0;
         KIND_APPEND: if (plan_fill < DEPTH) plan_fill++;
         KIND_INSERT: if (plan_fill < DEPTH && p <= plan_fill) plan_fill++;
         KIND_DELETE: if (plan_fill > 0 && p < plan_fill) plan_fill--;
         default:     ;
      endcase
   endtask

   // work out the result beats of one accepted operation and update the shadow array
   task automatic predict_array_op(input kind_type k, input logic [POS_W-1:0] p,
                                   input logic signed [VALUE_W-1:0] v);
      rsp_beat_type beat;
      int           at;
      at          = int'(p);
      beat.status = ST_OK;
      beat.data   = '0;
      beat.index  = '0;
      beat.last   = 1'b1;
      case (k)
         KIND_CLEAR: shadow_fill = 0;
         KIND_APPEND: begin
            if (shadow_fill >= DEPTH) begin
               beat.status = ST_FULL;
            end else begin
               shadow_words[shadow_fill] = v;
               shadow_fill++;
            end
         end
         KIND_INSERT: begin
            // full takes precedence over a bad position
            if (shadow_fill >= DEPTH) begin
               beat.status = ST_FULL;
            end else if (at > shadow_fill) begin
               beat.status = ST_BADPOS;
            end else begin
               for (int i = shadow_fill; i > at; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[at] = v;
               shadow_fill++;
            end
         end
         KIND_DELETE: begin
            // empty takes precedence over a bad position
            if (shadow_fill == 0) begin
               beat.status = ST_EMPTY;
            end else if (at >= shadow_fill) begin
               beat.status = ST_BADPOS;
            end else begin
               beat.data = shadow_words[at];
               for (int i = at; i + 1 < shadow_fill; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_fill--;
            end
         end
         KIND_DUMP: begin
            if (shadow_fill == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               // one beat per stored entry, last flag on the final one
               for (int i = 0; i < shadow_fill; i++) begin
                  beat.data  = shadow_words[i];
                  beat.index = INDEX_W'(i);
                  beat.count = COUNT_W'(shadow_fill);
                  beat.last  = (i + 1 == shadow_fill);
                  owed_rsp.push_back(beat);
               end
               return;
            end
         end
         default: ;
      endcase
      beat.count = COUNT_W'(shadow_fill);
      owed_rsp.push_back(beat);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: rsp_%s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // request driver: new beat or idle at the falling edge, hold while stalled
   always @(negedge clock) begin
      array_op_type op;
      logic         drive_valid;
      drive_valid = req_valid;
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         drive_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (req_beats + CALM_TAIL < total_items && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(1, 16) - 1;
         end else if (op_backlog.size() != 0 &&
                      !(op_backlog[0].drain_first && owed_rsp.size() != 0)) begin
            op           = op_backlog.pop_front();
            drive_valid  = 1'b1;
            req_kind     <= op.kind;
            req_position <= op.position;
            req_value    <= op.value;
         end
      end
      req_valid <= drive_valid;
   end

   // result stall: random bursts plus one long hold-off so the block backs up
   always @(negedge clock) begin
      logic stall_next;
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (!hold_done && req_beats >= HOLD_AT) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         stall_next = 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         stall_next = 1'b1;
      end else if (req_beats + CALM_TAIL < total_items && $urandom_range(0, 7) == 0) begin
         rsp_gap    = $urandom_range(1, 16) - 1;
         stall_next = 1'b1;
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // monitor: check result beats first, then predict from the accepted request beat
   always @(posedge clock) begin
      rsp_beat_type want;
      logic         accept_now;
      cycle_count++;
      accept_now = !reset && req_valid === 1'b1 && req_stall === 1'b0;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_beats++;
         if (owed_rsp.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: result beat with nothing expected, expected none, got status %0h data %0h",
                        $time, rsp_status, rsp_data);
         end else begin
            want = owed_rsp.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("data",   want.data,         rsp_data);
            check_field("index",  32'(want.index),  32'(rsp_index));
            check_field("count",  32'(want.count),  32'(rsp_count));
            check_field("last",   32'(want.last),   32'(rsp_last));
         end
      end
      req_taken <= accept_now;
      if (accept_now) begin
         predict_array_op(req_kind, req_position, req_value);
         op_seen[req_kind]++;
         req_beats++;
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, owed_rsp.size());
      $display("TB_ERROR");
      $finish;
   end

   // stimulus, reset and end of run
   initial begin
      int unsigned r;
      int          phase;
      int          edge_hits;
      bit          drain;
      for (int i = 0; i < 8; i++)
         op_seen[i] = 0;

      // directed: empty and bad-position precedence, extremes, every kind
      queue_op(KIND_DUMP,   6'd0,  32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd0,  32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd63, 32'sd0, 1'b0);
      queue_op(KIND_INSERT, 6'd1,  32'sd5, 1'b0);
      queue_op(KIND_INSERT, 6'd0,  32'h7fffffff, 1'b0);
      queue_op(KIND_APPEND, 6'd63, 32'h80000000, 1'b0);
      queue_op(KIND_APPEND, 6'd0,  32'h00000000, 1'b0);
      queue_op(KIND_INSERT, 6'd3,  32'hffffffff, 1'b0);
      queue_op(KIND_INSERT, 6'd0,  32'h55555555, 1'b0);
      queue_op(KIND_INSERT, 6'd2,  32'haaaaaaaa, 1'b0);
      queue_op(KIND_INSERT, 6'd7,  32'sd1, 1'b0);
      queue_op(KIND_INSERT, 6'd63, 32'sd2, 1'b0);
      queue_op(KIND_DELETE, 6'd6,  32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd63, 32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd5,  32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd0,  32'sd0, 1'b0);
      queue_op(KIND_DELETE, 6'd1,  32'sd0, 1'b0);
      queue_op(KIND_DUMP,   6'd63, 32'hffffffff, 1'b0);
      queue_op(kind_type'(5), 6'd63, 32'h12345678, 1'b0);
      queue_op(kind_type'(6), 6'd21, 32'hffffffff, 1'b0);
      queue_op(kind_type'(7), 6'd42, 32'h0, 1'b0);
      queue_op(KIND_CLEAR,  6'd63, 32'hdeadbeef, 1'b0);
      queue_op(KIND_DUMP,   6'd0,  32'sd0, 1'b0);
      queue_op(KIND_APPEND, 6'd0,  $urandom, 1'b0);
      queue_op(KIND_DUMP,   6'd0,  32'sd0, 1'b0);

      // random: grow until full, drain until empty, then a free mix
      phase     = 0;
      edge_hits = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         r     = $urandom_range(0, 99);
         drain = (i == DRAIN_AT);
         case (phase)
            0: begin
               if (plan_fill == DEPTH && r < 90)
                  edge_hits++;
               if (r < 45)
                  queue_op(KIND_APPEND, POS_W'($urandom), $urandom, drain);
               else if (r < 90)
                  queue_op(KIND_INSERT, POS_W'($urandom_range(0, plan_fill)), $urandom, drain);
               else if (r < 94)
                  queue_op(KIND_INSERT,
                           POS_W'((plan_fill < 63) ? $urandom_range(plan_fill + 1, 63)
                                                   : $urandom_range(0, 63)), $urandom, drain);
               else if (r < 97)
                  queue_op(KIND_DELETE,
                           POS_W'((plan_fill > 0) ? $urandom_range(0, plan_fill - 1) : 0),
                           $urandom, drain);
               else
                  queue_op(KIND_DUMP, POS_W'($urandom), $urandom, drain);
               if (edge_hits >= 3) begin
                  phase     = 1;
                  edge_hits = 0;
               end
            end
            1: begin
               if (plan_fill == 0 && r < 88)
                  edge_hits++;
               if (r < 80)
                  queue_op(KIND_DELETE,
                           POS_W'((plan_fill > 0) ? $urandom_range(0, plan_fill - 1)
                                                  : $urandom_range(0, 63)), $urandom, drain);
               else if (r < 88)
                  queue_op(KIND_DELETE,
                           POS_W'((plan_fill < DEPTH) ? $urandom_range(plan_fill, 63)
                                                      : $urandom_range(0, 63)), $urandom, drain);
               else if (r < 92)
                  queue_op(KIND_APPEND, POS_W'($urandom), $urandom, drain);
               else if (r < 96)
                  queue_op(KIND_INSERT, POS_W'($urandom_range(0, plan_fill)), $urandom, drain);
               else
                  queue_op(KIND_DUMP, POS_W'($urandom), $urandom, drain);
               if (edge_hits >= 2)
                  phase = 2;
            end
            default: begin
               if (r < 30)
                  queue_op(KIND_APPEND, POS_W'($urandom), $urandom, drain);
               else if (r < 55)
                  queue_op(KIND_INSERT, POS_W'($urandom_range(0, plan_fill)), $urandom, drain);
               else if (r < 80)
                  queue_op(KIND_DELETE,
                           POS_W'((plan_fill > 0) ? $urandom_range(0, plan_fill - 1)
                                                  : $urandom_range(0, 63)), $urandom, drain);
               else if (r < 87)
                  queue_op((r < 84) ? KIND_INSERT : KIND_DELETE, POS_W'($urandom), $urandom,
                           drain);
               else if (r < 93)
                  queue_op(KIND_DUMP, POS_W'($urandom), $urandom, drain);
               else if (r < 96)
                  queue_op(KIND_CLEAR, POS_W'($urandom), $urandom, drain);
               else
                  queue_op(kind_type'($urandom_range(5, 7)), POS_W'($urandom), $urandom, drain);
            end
         endcase
      end
      total_items = op_backlog.size();

      // hold reset, then release it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every request beat taken and every result beat in
      while (op_backlog.size() != 0 || req_beats < total_items || owed_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (owed_rsp.size() != 0) begin
         errors++;
         $display("%0t: %0d result beats never arrived", $time, owed_rsp.size());
      end
      $display("ran %0d request beats: clear %0d, append %0d, insert %0d, delete %0d, dump %0d,",
               req_beats, op_seen[KIND_CLEAR], op_seen[KIND_APPEND], op_seen[KIND_INSERT],
               op_seen[KIND_DELETE], op_seen[KIND_DUMP]);
      $display("unused kinds %0d; checked %0d result beats through full, empty and long stalls",
               op_seen[5] + op_seen[6] + op_seen[7], rsp_beats);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
